[sv/smlt_pkg.sv]
// Package for the sorted multimap list unit: operation and status codes,
// controller state encoding and datapath command/status structs. No dependencies.
package smlt_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    S_INIT   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_RD     = 10'b0000000100,
    S_EVAL   = 10'b0000001000,
    S_LINK_N = 10'b0000010000,
    S_LINK_P = 10'b0000100000,
    S_RM_RD  = 10'b0001000000,
    S_RM_WR  = 10'b0010000000,
    S_DONE   = 10'b0100000000,
    S_ACK    = 10'b1000000000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic init_wr;    // write link_next[init_idx] = init_idx+1 (null for the last) during init sweep
    logic load;       // latch input, set cur = head, prev = null
    logic hold;       // capture the matched value of a search hit
    logic advance;    // prev = cur, cur = next(cur)
    logic ins_write;  // write new entry at free head, link to cur
    logic ins_link;   // link prev (or head) to new entry
    logic rm_rd;      // read link of free/cur for remove
    logic rm_write;   // unlink cur, push to free list
    logic emit;       // drive a result
    status_e status;
    logic    found;
    logic    last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_done;
    logic free_empty;
    logic cur_valid;
    logic ord_ok;     // entry key ordered at or before input key
    logic key_eq;
    logic val_eq;
    logic steps_done;
  } stat_t;

endpackage

[sv/sorted_multimap_list_table_unit.sv]
// Sorted multimap list unit: top level joining controller and datapath.
// Each walked entry passes through S_RD and S_EVAL (one registered store read each);
// the last result is driven from S_ACK, S_RM_RD or S_DONE.
// One item at a time: the next start is taken in the cycle after the last result.
// Results strobe for one cycle, no stall. Reset is async; busy stays high through the init sweep.
// Depends on smlt_pkg, smlt_ctrl, smlt_datapath, smlt_ram.
module sorted_multimap_list_table_unit #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic [1:0]                   func_i,
  input  logic signed [KEY_BITS-1:0]   key_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         result_valid_o,
  output logic [1:0]                   status_o,
  output logic                         found_o,
  output logic signed [VALUE_BITS-1:0] found_value_o,
  output logic                         last_o,
  output logic [6:0]                   pair_count_o,
  output logic                         is_empty_o
);
  import smlt_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  desc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) desc_q <= 1'b0;
    else if (cfg_we_i) desc_q <= cfg_wdata_i;
  end

  smlt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .func_i, .busy_o(busy),
    .cmd_o(cmd), .stat_i(stat));

  smlt_datapath #(.Capacity(CAPACITY), .KeyBits(KEY_BITS), .ValueBits(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .order_descending_i(desc_q),
    .key_i, .value_i, .found_value_o, .pair_count_o, .is_empty_o);

  assign result_valid_o = cmd.emit;
  assign status_o       = cmd.status;
  assign found_o        = cmd.found;
  assign last_o         = cmd.last;
endmodule

[sv/smlt_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No package dependency.
module smlt_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[sv/smlt_datapath.sv]
// Datapath of the sorted multimap list unit: entry store RAMs, list pointers,
// walk cursor and key compare. Depends on smlt_pkg and smlt_ram.
module smlt_datapath #(
  parameter int Capacity  = 64,
  parameter int KeyBits   = 32,
  parameter int ValueBits = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  smlt_pkg::cmd_t              cmd_i,
  output smlt_pkg::stat_t             stat_o,
  input  logic                        order_descending_i,
  input  logic signed [KeyBits-1:0]   key_i,
  input  logic signed [ValueBits-1:0] value_i,
  output logic signed [ValueBits-1:0] found_value_o,
  output logic [6:0]                  pair_count_o,
  output logic                        is_empty_o
);
  import smlt_pkg::*;

  localparam int AW = $clog2(Capacity);
  localparam int PW = AW + 1;  // top bit flags null

  logic [PW-1:0] head_q, free_q, cur_q, prev_q;
  logic [PW-1:0] init_q;
  logic [6:0]    count_q;
  logic [PW:0]   steps_q;
  logic signed [KeyBits-1:0]   key_q;
  logic signed [ValueBits-1:0] val_q;
  logic signed [ValueBits-1:0] hold_q;

  logic [KeyBits-1:0]   ek;
  logic [ValueBits-1:0] ev;
  logic [PW-1:0]        en;

  logic           k_we, l_we;
  logic [AW-1:0]  k_wa, l_wa, l_ra;
  logic [PW-1:0]  l_wd;

  // second link write port emulated: freed entry's link update is registered and written in the next cycle
  logic          fix_q;
  logic [AW-1:0] fix_a_q;
  logic [PW-1:0] fix_d_q;

  function automatic logic nul(input logic [PW-1:0] p);
    return p[PW-1];
  endfunction

  always_comb begin
    k_we = cmd_i.ins_write;
    k_wa = free_q[AW-1:0];
    l_we = 1'b0;
    l_wa = cur_q[AW-1:0];
    l_wd = free_q;
    l_ra = cur_q[AW-1:0];
    if (cmd_i.init_wr) begin
      l_we = 1'b1;
      l_wa = init_q[AW-1:0];
      l_wd = (init_q == PW'(Capacity - 1)) ? {1'b1, AW'(0)} : init_q + 1'b1;
    end else if (cmd_i.ins_write) begin
      l_we = 1'b1;
      l_wa = free_q[AW-1:0];
      l_wd = cur_q;
    end else if (cmd_i.ins_link) begin
      l_we = !nul(prev_q);
      l_wa = prev_q[AW-1:0];
      l_wd = free_q;  // still old free head (new entry)
    end else if (cmd_i.rm_write) begin
      l_we = !nul(prev_q);
      l_wa = prev_q[AW-1:0];
      l_wd = en;
    end else if (fix_q) begin
      l_we = 1'b1;
      l_wa = fix_a_q;
      l_wd = fix_d_q;
    end
    if (cmd_i.rm_rd || cmd_i.ins_write) l_ra = free_q[AW-1:0];
  end

  smlt_ram #(.Width(KeyBits), .Depth(Capacity)) u_keys (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(key_q), .raddr_i(cur_q[AW-1:0]),
    .rdata_o(ek));
  smlt_ram #(.Width(ValueBits), .Depth(Capacity)) u_vals (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(val_q), .raddr_i(cur_q[AW-1:0]),
    .rdata_o(ev));
  smlt_ram #(.Width(PW), .Depth(Capacity)) u_link (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra),
    .rdata_o(en));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= {1'b1, AW'(0)};
      free_q  <= '0;
      init_q  <= '0;
      count_q <= '0;
      cur_q   <= '0;
      prev_q  <= '0;
      steps_q <= '0;
      fix_q   <= 1'b0;
      hold_q  <= '0;
    end else begin
      fix_q <= cmd_i.rm_write;
      if (cmd_i.init_wr) init_q <= init_q + 1'b1;
      if (cmd_i.load) begin
        key_q   <= key_i;
        val_q   <= value_i;
        cur_q   <= head_q;
        prev_q  <= {1'b1, AW'(0)};
        steps_q <= '0;
      end
      if (cmd_i.advance) begin
        prev_q  <= cur_q;
        cur_q   <= en;
        steps_q <= steps_q + 1'b1;
      end
      if (cmd_i.ins_link) begin
        if (nul(prev_q)) head_q <= free_q;
        free_q  <= en;  // link of old free head, read during ins_write
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.rm_write) begin
        if (nul(prev_q)) head_q <= en;
        free_q  <= cur_q;
        fix_a_q <= cur_q[AW-1:0];
        fix_d_q <= free_q;
        if (count_q != 0) count_q <= count_q - 1'b1;
      end
      if (cmd_i.hold) hold_q <= ev;
    end
  end

  logic sk, lt, gt;
  assign sk = $signed(ek) == key_q;
  assign lt = $signed(ek) < key_q;
  assign gt = $signed(ek) > key_q;

  assign stat_o.init_done  = (init_q == PW'(Capacity));
  assign stat_o.free_empty = nul(free_q);
  assign stat_o.cur_valid  = !nul(cur_q);
  assign stat_o.ord_ok     = sk || (order_descending_i ? gt : lt);
  assign stat_o.key_eq     = sk;
  assign stat_o.val_eq     = ev == val_q;
  assign stat_o.steps_done = steps_q >= (PW+1)'(Capacity);

  // a search hit is held until the walk shows whether it is the last one
  assign found_value_o = cmd_i.found ? hold_q : '0;
  assign pair_count_o  = count_q;
  assign is_empty_o    = nul(head_q);
endmodule

[sv/smlt_ctrl.sv]
// Controller of the sorted multimap list unit: sequences the list walk,
// insert, remove and result strobes. Depends on smlt_pkg.
module smlt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       func_i,
  output logic             busy_o,
  output smlt_pkg::cmd_t   cmd_o,
  input  smlt_pkg::stat_t  stat_i
);
  import smlt_pkg::*;

  state_e state_q, state_d;
  func_e  func_q;
  logic   nfound_q, nfound_d;
  logic   pend_q, pend_d;  // a search hit waits for its last flag

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    nfound_d = nfound_q;
    pend_d   = pend_q;
    cmd_o    = '0;
    cmd_o.status = ST_OK;
    case (state_q)
      S_INIT: begin
        if (stat_i.init_done) state_d = S_IDLE;
        else cmd_o.init_wr = 1'b1;
      end
      S_IDLE: begin
        if (start_i && func_i != FUNC_NONE) begin
          cmd_o.load = 1'b1;
          nfound_d = 1'b0;
          pend_d = 1'b0;
          if (func_i == FUNC_INSERT && stat_i.free_empty) state_d = S_DONE;
          else state_d = S_RD;
        end
      end
      S_RD: begin
        if (!stat_i.cur_valid || stat_i.steps_done) begin
          if (func_q == FUNC_INSERT) begin
            cmd_o.ins_write = 1'b1;
            state_d = S_LINK_P;
          end else state_d = S_DONE;
        end else state_d = S_EVAL;
      end
      S_EVAL: begin
        // read data for cur is now valid
        state_d = S_RD;
        case (func_q)
          FUNC_INSERT: begin
            if (stat_i.ord_ok) cmd_o.advance = 1'b1;
            else begin
              cmd_o.ins_write = 1'b1;
              state_d = S_LINK_P;
            end
          end
          FUNC_SEARCH: begin
            if (stat_i.ord_ok) begin
              cmd_o.advance = 1'b1;
              if (stat_i.key_eq) begin
                // send the previous hit, keep this one until the next is seen
                cmd_o.hold = 1'b1;
                pend_d = 1'b1;
                if (pend_q) begin
                  cmd_o.emit  = 1'b1;
                  cmd_o.found = 1'b1;
                end
              end
            end else state_d = S_DONE;
          end
          default: begin
            if (!stat_i.key_eq) begin
              if (nfound_q) state_d = S_DONE;
              else cmd_o.advance = 1'b1;
            end else if (!stat_i.val_eq) begin
              nfound_d = 1'b1;
              cmd_o.advance = 1'b1;
            end else state_d = S_RM_WR;
          end
        endcase
      end
      S_LINK_P: begin
        cmd_o.ins_link = 1'b1;
        state_d = S_ACK;
      end
      S_ACK: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = 1'b1;
        state_d = S_IDLE;
      end
      S_RM_WR: begin
        cmd_o.rm_write = 1'b1;
        state_d = S_RM_RD;
      end
      S_RM_RD: begin
        cmd_o.rm_rd = 1'b1;
        cmd_o.emit = 1'b1;
        cmd_o.last = 1'b1;
        state_d = S_IDLE;
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = 1'b1;
        if (func_q == FUNC_INSERT) cmd_o.status = ST_FULL;
        else if (func_q == FUNC_SEARCH && pend_q) cmd_o.found = 1'b1;
        else cmd_o.status = ST_NOT_FOUND;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      func_q   <= FUNC_NONE;
      nfound_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      nfound_q <= nfound_d;
      pend_q   <= pend_d;
      if (cmd_o.load) func_q <= func_e'(func_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE) else $error("load outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins_write |=> cmd_o.ins_link) else $error("insert not linked");
endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for sorted_multimap_list_table_unit: directed and random
// insert/search/remove traffic against a behavioral multimap predictor.
// Depends on smlt_pkg and the unit's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smlt_pkg::*;

  localparam int CAP = 64;
  localparam logic [6:0] NIL = 7'd127;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic signed [31:0] fval;
    logic               last;
    logic [6:0]         count;
    logic               empty;
  } answer_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic start = 1'b0, cfg_we_i = 1'b0, cfg_wdata_i = 1'b0;
  logic [1:0] func_i = FUNC_INSERT;
  logic signed [31:0] key_i = '0, value_i = '0;
  logic busy, result_valid_o, found_o, last_o, is_empty_o;
  logic [1:0] status_o;
  logic signed [31:0] found_value_o;
  logic [6:0] pair_count_o;

  sorted_multimap_list_table_unit #(.CAPACITY(CAP), .KEY_BITS(32), .VALUE_BITS(32)) DUT (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_wdata_i, .func_i, .key_i, .value_i,
    .result_valid_o, .status_o, .found_o, .found_value_o, .last_o, .pair_count_o,
    .is_empty_o
  );

  // predictor state
  logic signed [31:0] mm_key [CAP];
  logic signed [31:0] mm_val [CAP];
  logic [6:0] mm_next [CAP];
  logic [6:0] mm_head, mm_free, mm_count;
  logic mm_desc;

  answer_t pending_answers[$];
  int idle_pct = 0;
  int n_sent = 0, n_results = 0, n_errors = 0, n_full = 0, n_multi = 0;

  initial forever #4 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic bit ordered(logic signed [31:0] a, logic signed [31:0] b);
    return mm_desc ? (a >= b) : (a <= b);
  endfunction

  function automatic void push_answer(status_e s, logic f, logic signed [31:0] v,
                                      logic l);
    answer_t a;
    a.status = s; a.found = f; a.fval = v; a.last = l;
    a.count = mm_count; a.empty = (mm_head == NIL);
    pending_answers = {pending_answers, a};
  endfunction

  function automatic void multimap_apply(logic [1:0] f, logic signed [31:0] k,
                                         logic signed [31:0] v);
    logic [6:0] cur, prev, n;
    int hits;
    cur = mm_head; prev = NIL; hits = 0;
    case (f)
      FUNC_INSERT: begin
        if (mm_free == NIL) begin
          push_answer(ST_FULL, 1'b0, '0, 1'b1);
          n_full++;
        end else begin
          while (cur != NIL && ordered(mm_key[cur], k)) begin
            prev = cur; cur = mm_next[cur];
          end
          n = mm_free; mm_free = mm_next[n];
          mm_key[n] = k; mm_val[n] = v; mm_next[n] = cur;
          if (prev != NIL) mm_next[prev] = n;
          else mm_head = n;
          mm_count++;
          push_answer(ST_OK, 1'b0, '0, 1'b1);
        end
      end
      FUNC_SEARCH: begin
        while (cur != NIL && ordered(mm_key[cur], k)) begin
          if (mm_key[cur] == k) begin
            // mark the previous hit as not last, it is still queued
            push_answer(ST_OK, 1'b1, mm_val[cur], 1'b1);
            if (hits > 0) pending_answers[$-1].last = 1'b0;
            hits++;
          end
          cur = mm_next[cur];
        end
        if (hits == 0) push_answer(ST_NOT_FOUND, 1'b0, '0, 1'b1);
        if (hits > 1) n_multi++;
      end
      FUNC_REMOVE: begin
        while (cur != NIL && mm_key[cur] != k) begin
          prev = cur; cur = mm_next[cur];
        end
        while (cur != NIL && mm_key[cur] == k && mm_val[cur] != v) begin
          prev = cur; cur = mm_next[cur];
        end
        if (cur == NIL || mm_key[cur] != k || mm_val[cur] != v) begin
          push_answer(ST_NOT_FOUND, 1'b0, '0, 1'b1);
        end else begin
          if (prev != NIL) mm_next[prev] = mm_next[cur];
          else mm_head = mm_next[cur];
          mm_next[cur] = mm_free; mm_free = cur;
          if (mm_count > 0) mm_count--;
          push_answer(ST_OK, 1'b0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // one command transfer; start stays high when the next call does not idle
  task automatic send_op(logic [1:0] f, logic signed [31:0] k, logic signed [31:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1; func_i = f; key_i = k; value_i = v;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    multimap_apply(f, k, v);
    if (f != FUNC_NONE) n_sent++;
  endtask

  task automatic drain;
    @(negedge clk_i);
    start = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (2 * CAP + 12) @(negedge clk_i);
  endtask

  task automatic set_order(logic d);
    drain();
    cfg_we_i = 1'b1; cfg_wdata_i = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mm_desc = d;
  endtask

  // random stored pair, or random junk if the list is empty
  task automatic pick_pair(output logic signed [31:0] k, output logic signed [31:0] v);
    logic [6:0] p;
    int r;
    k = $urandom; v = $urandom;
    if (mm_count == 0) return;
    r = $urandom_range(mm_count - 1);
    p = mm_head;
    repeat (r) p = mm_next[p];
    k = mm_key[p]; v = mm_val[p];
  endtask

  function automatic logic signed [31:0] pool_key();
    return $urandom_range(9) < 8 ? 32'(signed'($urandom_range(12)) - 6) : $urandom;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      answer_t want;
      n_results++;
      if (pending_answers.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        want = pending_answers.pop_front();
        if (status_o != want.status || found_o != want.found ||
            found_value_o != want.fval || last_o != want.last ||
            pair_count_o != want.count || is_empty_o != want.empty) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch at %0t: exp st=%0d f=%0b v=%0d l=%0b n=%0d e=%0b",
                     $realtime, want.status, want.found, want.fval, want.last,
                     want.count, want.empty);
            $display("  got st=%0d f=%0b v=%0d l=%0b n=%0d e=%0b",
                     status_o, found_o, found_value_o, last_o, pair_count_o,
                     is_empty_o);
          end
        end
      end
    end
  end

  task automatic test_directed;
    send_op(FUNC_SEARCH, 32'sd5, '0);               // empty list on the first pass
    send_op(FUNC_REMOVE, 32'sd5, 32'sd1);
    send_op(FUNC_INSERT, 32'h7fffffff, 32'h80000000);
    send_op(FUNC_INSERT, 32'h80000000, 32'h7fffffff);
    send_op(FUNC_INSERT, 32'sd0, 32'sd0);
    send_op(FUNC_INSERT, 32'sd3, 32'sd10);
    send_op(FUNC_INSERT, 32'sd3, 32'sd11);           // equal keys keep arrival order
    send_op(FUNC_INSERT, 32'sd3, -32'sd1);
    send_op(FUNC_SEARCH, 32'sd3, 32'hffffffff);
    send_op(FUNC_SEARCH, 32'h80000000, '0);
    send_op(FUNC_SEARCH, 32'h7fffffff, '0);
    send_op(FUNC_SEARCH, 32'sd2, '0);
    send_op(FUNC_NONE, 32'sd3, 32'sd10);             // ignored
    send_op(FUNC_REMOVE, 32'sd3, 32'sd12);           // key hit, value miss
    send_op(FUNC_REMOVE, 32'sd3, 32'sd11);
    send_op(FUNC_SEARCH, 32'sd3, '0);
    send_op(FUNC_REMOVE, 32'h80000000, 32'h7fffffff);
    send_op(FUNC_REMOVE, 32'h7fffffff, 32'h80000000);
    send_op(FUNC_REMOVE, 32'sd0, 32'sd0);
  endtask

  task automatic test_random(int items);
    logic signed [31:0] k, v;
    int r, sent;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      if (r < 40) send_op(FUNC_INSERT, pool_key(), $urandom_range(9) < 5 ?
                          32'($urandom_range(3)) : 32'($urandom));
      else if (r < 65) begin
        pick_pair(k, v);
        send_op(FUNC_SEARCH, $urandom_range(3) == 0 ? pool_key() : k, $urandom);
      end else if (r < 95) begin
        pick_pair(k, v);
        if ($urandom_range(4) == 0) v = v ^ (32'd1 << $urandom_range(31));
        send_op(FUNC_REMOVE, k, v);
      end else begin
        send_op(FUNC_NONE, $urandom, $urandom);
        sent--;
      end
      sent++;
    end
  endtask

  task automatic test_full_store;
    logic signed [31:0] k, v;
    while (mm_free != NIL) send_op(FUNC_INSERT, pool_key(), $urandom);
    send_op(FUNC_INSERT, 32'sd1, 32'sd1);
    send_op(FUNC_INSERT, 32'h80000000, 32'sd2);
    send_op(FUNC_SEARCH, 32'sd0, '0);
    while (mm_count > 40) begin
      pick_pair(k, v);
      send_op(FUNC_REMOVE, k, v);
    end
  endtask

  initial begin
    mm_head = NIL; mm_free = 7'd0; mm_count = 7'd0; mm_desc = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      mm_key[i] = '0; mm_val[i] = '0;
      mm_next[i] = (i + 1 < CAP) ? 7'(i + 1) : NIL;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    set_order(1'b1);
    test_directed();
    idle_pct = 34;
    test_random(30);
    set_order(1'b0);                  // order flipped with pairs stored
    test_full_store();
    idle_pct = 54;
    test_random(30);
    set_order(1'b1);
    idle_pct = 0;
    test_random(30);
    set_order(1'b0);
    test_random(10);
    drain();

    $display("%0d operations, %0d results, %0d full rejects, %0d multi-value searches",
             n_sent, n_results, n_full, n_multi);
    $display("both key orders, order flips with pairs stored, idle rates 34/54/0");
    if (n_errors == 0) $display("Verification passed");
    else begin
      $display("%0d mismatches", n_errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
